FILE: src/lfu_cache_table_assert.svh
// Assertion macros used by the cache table datapath.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define LCT_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// An implication that must hold at every clock edge out of reset.
`define LCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/lct_pkg.sv
// Shared constants and controller/datapath interface types for the cache table.
package lct_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CAP_W = 5;

    localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(DEPTH);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic match;
        logic scan_start;
        logic scan_step;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_insert;
        logic full;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

FILE: src/lct_ctrl.sv
// Controller state machine that sequences lookup, victim scan and write-back.
module lct_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lct_pkg::status_t status,
    output lct_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Decode commands and the next state.
    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.match = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.scan_start = 1'b1;
                if (status.need_insert && status.full) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/lct_dp.sv
// Datapath: entry store, key match, victim scan, write-back and result register.
`include "lfu_cache_table_assert.svh"

module lct_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lct_pkg::cmd_t                      cmd,
    output lct_pkg::status_t                   status,
    input  logic [lct_pkg::FILL_W-1:0]         capacity,
    input  logic                               in_cmd,
    input  logic [lct_pkg::DATA_W-1:0]         in_key,
    input  logic [lct_pkg::DATA_W-1:0]         in_value,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               out_hit,
    output logic [lct_pkg::DATA_W-1:0]         out_read_value,
    output logic                               out_evicted,
    output logic [lct_pkg::DATA_W-1:0]         out_evicted_key
);

    localparam int D = lct_pkg::DEPTH;
    localparam int IW = lct_pkg::IDX_W;
    localparam int FW = lct_pkg::FILL_W;
    localparam int W = lct_pkg::DATA_W;

    // Entry store.
    logic [D-1:0]  valid_reg;
    logic [W-1:0]  key_reg   [D];
    logic [W-1:0]  value_reg [D];
    logic [W-1:0]  count_reg [D];
    logic [IW-1:0] rank_reg  [D];
    logic [FW-1:0] filled_reg;

    // Request registers.
    logic          cmd_reg;
    logic [W-1:0]  req_key_reg;
    logic [W-1:0]  req_value_reg;

    // Match results.
    logic [D-1:0]  match_oh;
    logic          hit_reg;
    logic [D-1:0]  hit_oh_reg;
    logic [W-1:0]  hit_value_reg;
    logic [IW-1:0] hit_rank_reg;
    logic [W-1:0]  hit_value_or;
    logic [IW-1:0] hit_rank_or;

    // Victim scan.
    logic [IW-1:0] scan_idx_reg;
    logic          any_reg;
    logic [D-1:0]  best_oh_reg;
    logic [W-1:0]  best_count_reg;
    logic [IW-1:0] best_rank_reg;
    logic [W-1:0]  best_key_reg;
    logic          scan_better;

    // Result register.
    logic          out_valid_reg;
    logic          out_hit_reg;
    logic [W-1:0]  out_rval_reg;
    logic          out_ev_reg;
    logic [W-1:0]  out_evkey_reg;

    logic          need_insert;
    logic [D-1:0]  free_oh;
    logic [D-1:0]  slot_oh;

    // Parallel key compare and one-hot read of the hit entry.
    always_comb begin
        hit_value_or = '0;
        hit_rank_or = '0;
        for (int i = 0; i < D; i++) begin
            match_oh[i] = valid_reg[i] && (key_reg[i] == req_key_reg);
            hit_value_or = hit_value_or | (value_reg[i] & {W{match_oh[i]}});
            hit_rank_or = hit_rank_or | (rank_reg[i] & {IW{match_oh[i]}});
        end
    end

    assign need_insert = !hit_reg && (cmd_reg == lct_pkg::CMD_PUT) && (capacity != '0);

    // Lowest free slot, or the victim's slot when one was evicted.
    assign free_oh = ~valid_reg & (valid_reg + D'(1));
    assign slot_oh = any_reg ? best_oh_reg : free_oh;

    // Victim ordering: lowest count, then oldest.
    assign scan_better = valid_reg[scan_idx_reg] && (!any_reg
        || (count_reg[scan_idx_reg] < best_count_reg)
        || ((count_reg[scan_idx_reg] == best_count_reg)
            && (rank_reg[scan_idx_reg] > best_rank_reg)));

    assign status.need_insert = need_insert;
    assign status.full = (filled_reg >= capacity);
    assign status.scan_last = (scan_idx_reg == IW'(D - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    // Request capture, match and scan registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= in_cmd;
            req_key_reg <= in_key;
            req_value_reg <= in_value;
        end
        if (cmd.match) begin
            hit_oh_reg <= match_oh;
            hit_value_reg <= hit_value_or;
            hit_rank_reg <= hit_rank_or;
        end
        if (cmd.scan_step && scan_better) begin
            best_oh_reg <= D'(1) << scan_idx_reg;
            best_count_reg <= count_reg[scan_idx_reg];
            best_rank_reg <= rank_reg[scan_idx_reg];
            best_key_reg <= key_reg[scan_idx_reg];
        end
    end

    // Control flags of the request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
            any_reg <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            if (cmd.match) begin
                hit_reg <= |match_oh;
            end
            if (cmd.scan_start) begin
                any_reg <= 1'b0;
                scan_idx_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
                if (scan_better) begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    // Entry payload write-back.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int i = 0; i < D; i++) begin
                if (hit_reg) begin
                    if (hit_oh_reg[i]) begin
                        if (cmd_reg == lct_pkg::CMD_PUT) begin
                            value_reg[i] <= req_value_reg;
                        end
                        if (count_reg[i] != lct_pkg::COUNT_MAX) begin
                            count_reg[i] <= count_reg[i] + W'(1);
                        end
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i] && rank_reg[i] < hit_rank_reg) begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end else if (need_insert) begin
                    if (slot_oh[i]) begin
                        key_reg[i] <= req_key_reg;
                        value_reg[i] <= req_value_reg;
                        count_reg[i] <= W'(1);
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i]
                                 && (!any_reg || rank_reg[i] < best_rank_reg)) begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end
            end
        end
    end

    // Valid bits and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            filled_reg <= '0;
        end else if (cmd.commit && !hit_reg && need_insert) begin
            valid_reg <= valid_reg | slot_oh;
            if (!any_reg) begin
                filled_reg <= filled_reg + FW'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg <= hit_reg;
            out_rval_reg <= (hit_reg && cmd_reg == lct_pkg::CMD_GET) ?
                hit_value_reg : lct_pkg::MISS_VALUE;
            out_ev_reg <= !hit_reg && need_insert && any_reg;
            out_evkey_reg <= (!hit_reg && need_insert && any_reg) ? best_key_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_hit = out_hit_reg;
    assign out_read_value = out_rval_reg;
    assign out_evicted = out_ev_reg;
    assign out_evicted_key = out_evkey_reg;

    // The fill never exceeds the store.
    `LCT_ASSERT(a_fill_bound, filled_reg <= FW'(D), "fill count above depth")
    // A scan only runs for a put that missed.
    `LCT_ASSERT_IMP(a_scan_miss, cmd.scan_step, !hit_reg && need_insert, "scan on hit")
    // A result is never overwritten before it is taken.
    `LCT_ASSERT_IMP(a_no_overwrite, cmd.commit, !out_valid_reg || m_tready,
        "result overwritten")

endmodule

FILE: src/lfu_cache_table.sv
// Top level: configuration port, stream ports, controller and datapath.
// A key/value store of 16 entries with least-frequently-used replacement and
// least-recently-used tie-break. Each request is taken when s_tready is high and
// produces one result. A get, a put that hits, or a put that inserts into a
// store below capacity passes through key match, decision and write-back. A put
// that misses on a full store adds a victim scan before the write-back that
// visits every entry in the store, one entry per cycle. The write-back waits
// while an earlier result is still held by m_tready low. The next request is
// taken as soon as the write-back has loaded the result register, even while
// that result still waits on m_tready. Capacity (address 0) saturates at 16 and
// should be written only while the block is idle.
module lfu_cache_table (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] write_value
    input  logic        s_tuser,   // [0] cmd
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] hit, [32:1] read_value, [33] evicted,
                                   // [65:34] evicted_key, [71:66] zero
);

    logic [lct_pkg::FILL_W-1:0] capacity_reg;
    logic [lct_pkg::CAP_W-1:0]  wr_cap;
    lct_pkg::cmd_t              cmd;
    lct_pkg::status_t           status;
    logic                       out_hit;
    logic [31:0]                out_read_value;
    logic                       out_evicted;
    logic [31:0]                out_evicted_key;

    assign pready = 1'b1;
    assign wr_cap = pwdata[lct_pkg::CAP_W-1:0];

    // Capacity register, written from the low five bits of pwdata and saturated to the store depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lct_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == lct_pkg::REG_CAPACITY) begin
            if (wr_cap > lct_pkg::CAP_W'(lct_pkg::DEPTH)) begin
                capacity_reg <= lct_pkg::FILL_W'(lct_pkg::DEPTH);
            end else begin
                capacity_reg <= lct_pkg::FILL_W'(wr_cap);
            end
        end
    end

    assign prdata = (paddr[2] == lct_pkg::REG_CAPACITY) ? 32'(capacity_reg) : '0;

    lct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lct_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .capacity        (capacity_reg),
        .in_cmd          (s_tuser),
        .in_key          (s_tdata[31:0]),
        .in_value        (s_tdata[63:32]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_hit         (out_hit),
        .out_read_value  (out_read_value),
        .out_evicted     (out_evicted),
        .out_evicted_key (out_evicted_key)
    );

    assign m_tdata = {6'b0, out_evicted_key, out_evicted, out_read_value, out_hit};

endmodule
